/* src/wisd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wisd_pkg: shared types and constants of the instruction stream decoder
// Opcode classes, decoder phases, the classified byte word and the result
// word, together with the opcode table lookup.
// ----------------------------------------------------------------------------
package wisd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned KindW   = 4;
	localparam int unsigned ValW    = 64;
	localparam int unsigned PosW    = 32;
	localparam int unsigned CountW  = 4;
	// The eleventh byte of a LEB128 number and those after it carry no bits.
	localparam logic [CountW-1:0] LebMaxBytes = 4'd10;
	localparam logic [CountW-1:0] LebSxLimit  = 4'd9;
	localparam logic [CountW-1:0] CountSat    = 4'd15;
	localparam logic [CountW-1:0] Raw32Bytes  = 4'd4;
	localparam logic [CountW-1:0] Raw64Bytes  = 4'd8;

	typedef enum logic [KindW-1:0] {
		KIND_NONE      = 4'd0,
		KIND_BLOCKTYPE = 4'd1,
		KIND_FLAGBYTE  = 4'd2,
		KIND_U32       = 4'd3,
		KIND_S32       = 4'd4,
		KIND_S64       = 4'd5,
		KIND_RAW32     = 4'd6,
		KIND_RAW64     = 4'd7,
		KIND_BRTABLE   = 4'd8,
		KIND_CALLIND   = 4'd9,
		KIND_MEMORY    = 4'd10
	} imm_kind_t;

	typedef enum logic [3:0] {
		PH_OPCODE   = 4'd0,
		PH_BYTE     = 4'd1,
		PH_LEB      = 4'd2,
		PH_RESERVED = 4'd3,
		PH_OFFSET   = 4'd4,
		PH_RAW      = 4'd5,
		PH_COUNT    = 4'd6,
		PH_TARGET   = 4'd7,
		PH_DEFAULT  = 4'd8
	} phase_t;

	// One classified stream byte as it travels from the front to the back.
	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             restart;
		imm_kind_t        kind;
	} item_t;

	typedef struct packed {
		logic [ByteW-1:0] opcode;
		imm_kind_t        kind;
		logic [ValW-1:0]  value_main;
		logic [ValW-1:0]  value_second;
		logic [PosW-1:0]  entry_pos;
		logic             is_default;
		logic             last;
		logic             overlong;
	} result_t;

	// Immediate class of an MVP opcode; unlisted opcodes carry no immediate.
	function automatic imm_kind_t kind_of(input logic [ByteW-1:0] op);
		imm_kind_t k;
		k = KIND_NONE;
		if (op >= 8'h02 && op <= 8'h04) begin
			k = KIND_BLOCKTYPE;
		end else if (op == 8'h0c || op == 8'h0d || op == 8'h10) begin
			k = KIND_U32;
		end else if (op == 8'h0e) begin
			k = KIND_BRTABLE;
		end else if (op == 8'h11) begin
			k = KIND_CALLIND;
		end else if (op >= 8'h20 && op <= 8'h24) begin
			k = KIND_U32;
		end else if (op >= 8'h28 && op <= 8'h3e) begin
			k = KIND_MEMORY;
		end else if (op == 8'h3f || op == 8'h40) begin
			k = KIND_FLAGBYTE;
		end else if (op == 8'h41) begin
			k = KIND_S32;
		end else if (op == 8'h42) begin
			k = KIND_S64;
		end else if (op == 8'h43) begin
			k = KIND_RAW32;
		end else if (op == 8'h44) begin
			k = KIND_RAW64;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

/* src/wisd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wisd_front: input stage and opcode classification
// Registers each incoming word together with the immediate class that the
// byte would have as an opcode, and hands it on to the queue.
// ----------------------------------------------------------------------------
module wisd_front import wisd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [ByteW-1:0] in_byte,
	input  wire logic             in_restart,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output item_t                 push_item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data    <= in_byte;
			item_s1.restart <= in_restart;
			item_s1.kind    <= kind_of(in_byte);
		end
	end

endmodule
`default_nettype wire

/* src/wisd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wisd_queue: short queue between front and back
// A first-in first-out store of classified words, so that the front and the
// back can each stall without holding up the other while words or room remain.
// ----------------------------------------------------------------------------
module wisd_queue import wisd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

	item_t           entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != Full);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* src/wisd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wisd_back: immediate assembly and result register
// Walks through the phases of one instruction, collects LEB128 and raw
// immediates, and loads finished results into the output register.
// ----------------------------------------------------------------------------
module wisd_back import wisd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pop_valid,
	output logic       pop_ready,
	input  wire item_t pop_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    out_result
);

	phase_t            phase_q, phase_d;
	logic [ByteW-1:0]  opcode_q, opcode_d;
	imm_kind_t         kind_q, kind_d;
	logic [ValW-1:0]   acc_q, acc_d;
	logic [CountW-1:0] cnt_q, cnt_d;
	logic [PosW-1:0]   first_q, first_d;
	logic [PosW-1:0]   left_q, left_d;
	logic [PosW-1:0]   index_q, index_d;
	logic              bad_q, bad_d;

	logic              out_valid_q;
	result_t           out_q;

	logic              pop;
	logic              is_op;
	logic [ByteW-1:0]  b;

	// LEB128 step
	logic [6:0]        shamt;
	logic [6:0]        sx_shamt;
	logic [ValW-1:0]   leb_acc;
	logic              leb_done;
	logic              leb_bad;
	logic              leb_sgn;
	logic [CountW-1:0] cnt_inc;

	// raw little-endian step
	logic [ValW-1:0]   raw_acc;
	logic [CountW-1:0] raw_cnt;
	logic              raw_done;

	logic              emit;
	result_t           res;

	assign pop_ready  = !out_valid_q || out_ready;
	assign pop        = pop_valid && pop_ready;
	assign is_op      = pop_item.restart || (phase_q == PH_OPCODE);
	assign b          = pop_item.data;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	always_comb begin
		shamt    = ({3'b000, cnt_q} << 3) - {3'b000, cnt_q};
		sx_shamt = shamt + 7'd7;
		leb_sgn  = (kind_q == KIND_S32) || (kind_q == KIND_S64);
		leb_done = !b[7];
		leb_bad  = bad_q || (cnt_q >= LebMaxBytes);
		cnt_inc  = (cnt_q == CountSat) ? cnt_q : cnt_q + 1'b1;
		leb_acc  = acc_q;
		if (cnt_q < LebMaxBytes) begin
			leb_acc = leb_acc | ({57'd0, b[6:0]} << shamt[5:0]);
		end
		if (leb_done && leb_sgn && cnt_q < LebSxLimit && b[6]) begin
			leb_acc = leb_acc | ({ValW{1'b1}} << sx_shamt[5:0]);
		end
		raw_acc = acc_q;
		if (cnt_q < Raw64Bytes) begin
			raw_acc = raw_acc | ({56'd0, b} << {cnt_q[2:0], 3'b000});
		end
		raw_cnt  = cnt_q + 1'b1;
		raw_done = raw_cnt >= ((kind_q == KIND_RAW32) ? Raw32Bytes : Raw64Bytes);
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		kind_d   = kind_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		first_d  = first_q;
		left_d   = left_q;
		index_d  = index_q;
		bad_d    = bad_q;
		if (pop) begin
			if (is_op) begin
				opcode_d = b;
				kind_d   = pop_item.kind;
				bad_d    = 1'b0;
				acc_d    = '0;
				cnt_d    = '0;
				first_d  = '0;
				left_d   = '0;
				index_d  = '0;
				unique case (pop_item.kind)
					KIND_NONE:                     phase_d = PH_OPCODE;
					KIND_BLOCKTYPE, KIND_FLAGBYTE: phase_d = PH_BYTE;
					KIND_RAW32, KIND_RAW64:        phase_d = PH_RAW;
					KIND_BRTABLE:                  phase_d = PH_COUNT;
					default:                       phase_d = PH_LEB;
				endcase
			end else begin
				unique case (phase_q)
					PH_BYTE, PH_RESERVED: begin
						phase_d = PH_OPCODE;
					end
					PH_LEB: begin
						acc_d = leb_acc;
						cnt_d = cnt_inc;
						bad_d = leb_bad;
						if (leb_done) begin
							if (kind_q == KIND_CALLIND) begin
								first_d = leb_acc[PosW-1:0];
								phase_d = PH_RESERVED;
							end else if (kind_q == KIND_MEMORY) begin
								first_d = leb_acc[PosW-1:0];
								acc_d   = '0;
								cnt_d   = '0;
								phase_d = PH_OFFSET;
							end else begin
								phase_d = PH_OPCODE;
							end
						end
					end
					PH_OFFSET, PH_DEFAULT: begin
						acc_d = leb_acc;
						cnt_d = cnt_inc;
						bad_d = leb_bad;
						if (leb_done) begin
							phase_d = PH_OPCODE;
						end
					end
					PH_RAW: begin
						acc_d = raw_acc;
						cnt_d = raw_cnt;
						if (raw_done) begin
							phase_d = PH_OPCODE;
						end
					end
					PH_COUNT: begin
						acc_d = leb_acc;
						cnt_d = cnt_inc;
						bad_d = leb_bad;
						if (leb_done) begin
							left_d  = leb_acc[PosW-1:0];
							index_d = '0;
							acc_d   = '0;
							cnt_d   = '0;
							phase_d = (leb_acc[PosW-1:0] != '0) ? PH_TARGET : PH_DEFAULT;
						end
					end
					PH_TARGET: begin
						acc_d = leb_acc;
						cnt_d = cnt_inc;
						bad_d = leb_bad;
						if (leb_done) begin
							index_d = index_q + 1'b1;
							left_d  = left_q - 1'b1;
							acc_d   = '0;
							cnt_d   = '0;
							if (left_q == PosW'(1)) begin
								phase_d = PH_DEFAULT;
							end
						end
					end
					default: begin
						phase_d = PH_OPCODE;
					end
				endcase
			end
		end
	end

	// Result for the current word
	always_comb begin
		emit             = 1'b0;
		res              = '0;
		res.opcode       = opcode_q;
		res.kind         = kind_q;
		res.last         = 1'b1;
		res.overlong     = leb_bad;
		if (is_op) begin
			emit         = (pop_item.kind == KIND_NONE);
			res.opcode   = b;
			res.kind     = pop_item.kind;
			res.overlong = 1'b0;
		end else begin
			unique case (phase_q)
				PH_BYTE: begin
					emit           = 1'b1;
					res.value_main = {56'd0, b};
					res.overlong   = bad_q;
				end
				PH_LEB: begin
					emit = leb_done && (kind_q != KIND_CALLIND) && (kind_q != KIND_MEMORY);
					if (kind_q == KIND_S32) begin
						res.value_main = {{32{leb_acc[31]}}, leb_acc[31:0]};
					end else if (kind_q == KIND_S64) begin
						res.value_main = leb_acc;
					end else begin
						res.value_main = {32'd0, leb_acc[31:0]};
					end
				end
				PH_RESERVED: begin
					emit             = 1'b1;
					res.value_main   = {32'd0, first_q};
					res.value_second = {56'd0, b};
					res.overlong     = bad_q;
				end
				PH_OFFSET: begin
					emit             = leb_done;
					res.value_main   = {32'd0, first_q};
					res.value_second = {32'd0, leb_acc[31:0]};
				end
				PH_RAW: begin
					emit           = raw_done;
					res.value_main = raw_acc;
					res.overlong   = bad_q;
				end
				PH_TARGET: begin
					emit           = leb_done;
					res.value_main = {32'd0, leb_acc[31:0]};
					res.entry_pos  = index_q;
					res.last       = 1'b0;
				end
				PH_DEFAULT: begin
					emit           = leb_done;
					res.value_main = {32'd0, leb_acc[31:0]};
					res.entry_pos  = index_q;
					res.is_default = 1'b1;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPCODE;
			opcode_q    <= '0;
			kind_q      <= KIND_NONE;
			acc_q       <= '0;
			cnt_q       <= '0;
			first_q     <= '0;
			left_q      <= '0;
			index_q     <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			kind_q   <= kind_d;
			acc_q    <= acc_d;
			cnt_q    <= cnt_d;
			first_q  <= first_d;
			left_q   <= left_d;
			index_q  <= index_d;
			bad_q    <= bad_d;
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q <= res;
		end
	end

	a_target_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TARGET) |-> (left_q != '0))
		else $error("target phase with no targets left");

	a_default_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_default) |-> out_q.last)
		else $error("default target result without last");

	a_only_brtable_splits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != KIND_BRTABLE) |-> out_q.last)
		else $error("result outside a branch table without last");

	a_op_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_op && pop_item.kind == KIND_NONE) |=> (phase_q == PH_OPCODE))
		else $error("opcode without immediate left decoder busy");

endmodule
`default_nettype wire

/* src/wasm_instruction_stream_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wasm_instruction_stream_decoder: WebAssembly MVP instruction decoder
// Turns a function body, one byte per word, into decoded instructions with
// their immediates assembled.
// ----------------------------------------------------------------------------
// The slave side takes one byte of the instruction stream per word; the
// tuser bit marks a byte that must be taken as a fresh opcode, dropping any
// instruction still being collected. The master side gives one word per
// finished instruction, and for a branch table one word per target plus one
// for the default, with tlast on the final word of each instruction.
// Throughput is one byte per clock cycle while the receiver takes results
// as they come. A byte that completes an instruction passes through the
// classifying input register and the queue, and its result is then loaded
// into the output register, from which the receiver takes the word.
// The back holds the only loop (the phase and accumulator update), and it
// retires one byte per cycle unless a stalled receiver holds a result in
// the output register.
// When the receiver stalls with a result waiting in the output register, the
// back stops taking bytes until that word is taken; the queue then fills
// and s_tready falls once both the queue and the input register are full.
// Reset clears the queue, empties the output register and puts the decoder
// in the state where it expects an opcode.
// ----------------------------------------------------------------------------
module wasm_instruction_stream_decoder import wisd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] byte_in
	input  wire logic [0:0]   s_tuser,   // [0] restart
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [175:0]      m_tdata,   // [7:0] opcode, [71:8] value_main,
	                                     // [135:72] value_second,
	                                     // [167:136] entry_pos, [168] overlong,
	                                     // [175:169] zero
	output logic [4:0]        m_tuser,   // [3:0] imm_kind, [4] is_default
	output logic              m_tlast
);

	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    pop_valid;
	logic    pop_ready;
	item_t   pop_item;
	result_t res;

	// Front: registers each word and classifies the byte as an opcode.
	wisd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_restart (s_tuser[0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Queue decoupling the front from the back.
	wisd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back: phase machine, immediate assembly and output register.
	wisd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (res)
	);

	// Pack the result word onto the master side.
	assign m_tdata = {7'd0, res.overlong, res.entry_pos, res.value_second,
	                  res.value_main, res.opcode};
	assign m_tuser = {res.is_default, res.kind};
	assign m_tlast = res.last;

endmodule
`default_nettype wire
